FILE: src/round_robin_task_table_defines.svh
// Assertion macros for the task table checker.
`ifndef ROUND_ROBIN_TASK_TABLE_DEFINES_SVH
`define ROUND_ROBIN_TASK_TABLE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define RRTT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrtt check failed");

// Next-cycle implication, disabled in reset.
`define RRTT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrtt check failed");

`endif

FILE: src/rrtt_pkg.sv
`timescale 1ns / 1ps

package rrtt_pkg;

    localparam int NUM_TASKS = 16;
    localparam int IDX_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);

    localparam logic [1:0] CMD_CREATE = 2'd0;
    localparam logic [1:0] CMD_TICK   = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [1:0] ST_UNUSED  = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_PAUSED  = 2'd2;
    localparam logic [1:0] ST_RUNNING = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN_C = 5'b00010,
        S_SCAN_T = 5'b00100,
        S_READ   = 5'b01000,
        S_FETCH  = 5'b10000
    } fsm_t;

endpackage

FILE: src/round_robin_task_table.sv
`timescale 1ns / 1ps

// Round-robin task table.
// Command channel: an item (command, stack_size, entry_address, task_index)
// is taken on a clock edge with start high and busy low.
// Result channel: done is high for exactly one cycle with slot_id, ok,
// slot_state, slot_stack_size and slot_entry; the receiver cannot stall it.
// One slot pointer walks the state table one slot a cycle; slot data sits
// in a single-port table with a registered read.
// Steps to done: a create scans from slot 0 for the first unused slot,
// marks it ready, writes its data and reads it back, or fails at the last
// slot on a full table. A tick pauses the current slot, scans on from the
// next slot, wrapping, to a ready or paused one, marks it running and reads
// it back. A query reads its slot; a bad index or command fails from idle.
// One item at a time: busy stays high until the result cycle, and a new
// item may be taken in the cycle that done is high.
// Reset clears all slots to unused, the current task to slot 0 and the
// written flags, so never-written slot data reads as zero.
module round_robin_task_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [31:0] stack_size,
    input  logic [31:0] entry_address,
    input  logic [3:0]  task_index,
    output logic        done,
    output logic [3:0]  slot_id,
    output logic        ok,
    output logic [1:0]  slot_state,
    output logic [31:0] slot_stack_size,
    output logic [31:0] slot_entry
);

    rrtt_pkg::fsm_t fsm_reg, fsm_next;

    logic [1:0]                 tstate_reg [rrtt_pkg::NUM_TASKS];
    logic [1:0]                 tstate_next [rrtt_pkg::NUM_TASKS];
    logic [rrtt_pkg::NUM_TASKS-1:0] wr_valid_reg, wr_valid_next;
    logic [rrtt_pkg::IDX_W-1:0] cur_reg, cur_next;
    logic [rrtt_pkg::IDX_W-1:0] ptr_reg, ptr_next;
    logic [rrtt_pkg::IDX_W-1:0] ptr_inc;
    logic [31:0]                stk_reg, stk_next;
    logic [31:0]                ent_reg, ent_next;
    logic                       ok_int_reg, ok_int_next;

    logic [63:0]                mem_reg [rrtt_pkg::NUM_TASKS];
    logic [63:0]                rd_data_reg;
    logic                       mem_we;

    logic                       done_reg, done_next;
    logic [3:0]                 slot_id_reg, slot_id_next;
    logic                       ok_reg, ok_next;
    logic [1:0]                 slot_state_reg, slot_state_next;
    logic [31:0]                stack_out_reg, stack_out_next;
    logic [31:0]                entry_out_reg, entry_out_next;

    logic [1:0]                 ptr_state;

    assign ptr_state = tstate_reg[ptr_reg];
    assign ptr_inc   = (ptr_reg == rrtt_pkg::LAST_IDX) ? '0 : ptr_reg + 1'b1;

    always_comb
    begin
        fsm_next        = fsm_reg;
        tstate_next     = tstate_reg;
        wr_valid_next   = wr_valid_reg;
        cur_next        = cur_reg;
        ptr_next        = ptr_reg;
        stk_next        = stk_reg;
        ent_next        = ent_reg;
        ok_int_next     = ok_int_reg;
        mem_we          = 1'b0;
        done_next       = 1'b0;
        slot_id_next    = slot_id_reg;
        ok_next         = ok_reg;
        slot_state_next = slot_state_reg;
        stack_out_next  = stack_out_reg;
        entry_out_next  = entry_out_reg;

        case (fsm_reg)
            rrtt_pkg::S_IDLE:
            begin
                if (start)
                begin
                    stk_next = stack_size;
                    ent_next = entry_address;
                    case (command)
                        rrtt_pkg::CMD_CREATE:
                        begin
                            ptr_next = '0;
                            fsm_next = rrtt_pkg::S_SCAN_C;
                        end
                        rrtt_pkg::CMD_TICK:
                        begin
                            tstate_next[cur_reg] = rrtt_pkg::ST_PAUSED;
                            ptr_next = (cur_reg == rrtt_pkg::LAST_IDX) ? '0 : cur_reg + 1'b1;
                            fsm_next = rrtt_pkg::S_SCAN_T;
                        end
                        rrtt_pkg::CMD_QUERY:
                        begin
                            if (32'(task_index) < 32'(rrtt_pkg::NUM_TASKS))
                            begin
                                ptr_next    = rrtt_pkg::IDX_W'(task_index);
                                ok_int_next = 1'b1;
                                fsm_next    = rrtt_pkg::S_READ;
                            end
                            else
                            begin
                                done_next       = 1'b1;
                                slot_id_next    = task_index;
                                ok_next         = 1'b0;
                                slot_state_next = rrtt_pkg::ST_UNUSED;
                                stack_out_next  = '0;
                                entry_out_next  = '0;
                            end
                        end
                        default:
                        begin
                            done_next       = 1'b1;
                            slot_id_next    = '0;
                            ok_next         = 1'b0;
                            slot_state_next = rrtt_pkg::ST_UNUSED;
                            stack_out_next  = '0;
                            entry_out_next  = '0;
                        end
                    endcase
                end
            end
            rrtt_pkg::S_SCAN_C:
            begin
                if (ptr_state == rrtt_pkg::ST_UNUSED)
                begin
                    tstate_next[ptr_reg]   = rrtt_pkg::ST_READY;
                    wr_valid_next[ptr_reg] = 1'b1;
                    mem_we                 = 1'b1;
                    ok_int_next            = 1'b1;
                    fsm_next               = rrtt_pkg::S_READ;
                end
                else if (ptr_reg == rrtt_pkg::LAST_IDX)
                begin
                    // table full
                    done_next       = 1'b1;
                    slot_id_next    = '0;
                    ok_next         = 1'b0;
                    slot_state_next = rrtt_pkg::ST_UNUSED;
                    stack_out_next  = '0;
                    entry_out_next  = '0;
                    fsm_next        = rrtt_pkg::S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_inc;
                end
            end
            rrtt_pkg::S_SCAN_T:
            begin
                if (ptr_state == rrtt_pkg::ST_READY || ptr_state == rrtt_pkg::ST_PAUSED)
                begin
                    tstate_next[ptr_reg] = rrtt_pkg::ST_RUNNING;
                    cur_next             = ptr_reg;
                    ok_int_next          = 1'b1;
                    fsm_next             = rrtt_pkg::S_READ;
                end
                else
                begin
                    ptr_next = ptr_inc;
                end
            end
            rrtt_pkg::S_READ:
            begin
                fsm_next = rrtt_pkg::S_FETCH;
            end
            rrtt_pkg::S_FETCH:
            begin
                done_next       = 1'b1;
                slot_id_next    = 4'(ptr_reg);
                ok_next         = ok_int_reg;
                slot_state_next = ptr_state;
                stack_out_next  = wr_valid_reg[ptr_reg] ? rd_data_reg[63:32] : '0;
                entry_out_next  = wr_valid_reg[ptr_reg] ? rd_data_reg[31:0] : '0;
                fsm_next        = rrtt_pkg::S_IDLE;
            end
            default:
            begin
                fsm_next = rrtt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg      <= rrtt_pkg::S_IDLE;
            wr_valid_reg <= '0;
            cur_reg      <= '0;
            ptr_reg      <= '0;
            done_reg     <= 1'b0;
            for (int i = 0; i < rrtt_pkg::NUM_TASKS; i++)
            begin
                tstate_reg[i] <= rrtt_pkg::ST_UNUSED;
            end
        end
        else
        begin
            fsm_reg      <= fsm_next;
            wr_valid_reg <= wr_valid_next;
            cur_reg      <= cur_next;
            ptr_reg      <= ptr_next;
            done_reg     <= done_next;
            tstate_reg   <= tstate_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stk_reg        <= stk_next;
        ent_reg        <= ent_next;
        ok_int_reg     <= ok_int_next;
        slot_id_reg    <= slot_id_next;
        ok_reg         <= ok_next;
        slot_state_reg <= slot_state_next;
        stack_out_reg  <= stack_out_next;
        entry_out_reg  <= entry_out_next;
    end

    // slot data table: one write, one registered read at the pointer
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_reg[ptr_reg] <= {stk_reg, ent_reg};
        end
        rd_data_reg <= mem_reg[ptr_reg];
    end

    assign busy            = (fsm_reg != rrtt_pkg::S_IDLE);
    assign done            = done_reg;
    assign slot_id         = slot_id_reg;
    assign ok              = ok_reg;
    assign slot_state      = slot_state_reg;
    assign slot_stack_size = stack_out_reg;
    assign slot_entry      = entry_out_reg;

endmodule

FILE: src/rrtt_checker.sv
`timescale 1ns / 1ps
`include "round_robin_task_table_defines.svh"

module rrtt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        ok,
    input logic [1:0]  slot_state,
    input logic [31:0] slot_stack_size,
    input logic [31:0] slot_entry
);

    // result cycle always finds the block ready for the next item
    `RRTT_ASSERT_NOW(a_done_idle, done, !busy)

    // an accepted item either answers at once or keeps the block busy
    `RRTT_ASSERT_NEXT(a_accept_progress, start && !busy, done || busy)

    // failed results carry no slot contents
    `RRTT_ASSERT_NOW(a_fail_zero, done && !ok,
        slot_state == rrtt_pkg::ST_UNUSED && slot_stack_size == 32'd0 && slot_entry == 32'd0)

    // an unused slot was never written
    `RRTT_ASSERT_NOW(a_unused_zero, done && ok && slot_state == rrtt_pkg::ST_UNUSED,
        slot_stack_size == 32'd0 && slot_entry == 32'd0)

endmodule

bind round_robin_task_table rrtt_checker u_rrtt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .done            (done),
    .ok              (ok),
    .slot_state      (slot_state),
    .slot_stack_size (slot_stack_size),
    .slot_entry      (slot_entry)
);

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 2 * rrtt_pkg::NUM_TASKS + 8;

    typedef struct packed {
        logic [3:0]  slot_id;
        logic        ok;
        logic [1:0]  slot_state;
        logic [31:0] slot_stack_size;
        logic [31:0] slot_entry;
    } task_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  command;
    logic [31:0] stack_size;
    logic [31:0] entry_address;
    logic [3:0]  task_index;
    logic        done;
    logic [3:0]  slot_id;
    logic        ok;
    logic [1:0]  slot_state;
    logic [31:0] slot_stack_size;
    logic [31:0] slot_entry;

    logic [1:0]  model_state [rrtt_pkg::NUM_TASKS];
    logic [31:0] model_stack [rrtt_pkg::NUM_TASKS];
    logic [31:0] model_entry [rrtt_pkg::NUM_TASKS];
    int          model_current;

    task_result_t expected_results [$];
    int           error_count;
    int           cycle_count;
    int           idle_pct;

    round_robin_task_table u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .command         (command),
        .stack_size      (stack_size),
        .entry_address   (entry_address),
        .task_index      (task_index),
        .done            (done),
        .slot_id         (slot_id),
        .ok              (ok),
        .slot_state      (slot_state),
        .slot_stack_size (slot_stack_size),
        .slot_entry      (slot_entry)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic task_result_t slot_report(int slot);
        task_result_t r;
        r.slot_id         = slot[3:0];
        r.ok              = 1'b1;
        r.slot_state      = model_state[slot];
        r.slot_stack_size = model_stack[slot];
        r.slot_entry      = model_entry[slot];
        return r;
    endfunction

    function automatic task_result_t predict_table_result(input logic [1:0] cmd,
                                                          input logic [31:0] stk,
                                                          input logic [31:0] ent,
                                                          input logic [3:0] idx);
        task_result_t r;
        bit           found;
        int           slot;
        int           cand;
        r = '0;
        found = 1'b0;
        case (cmd)
            rrtt_pkg::CMD_CREATE:
            begin
                for (slot = 0; slot < rrtt_pkg::NUM_TASKS; slot++)
                begin
                    if (!found && model_state[slot] == rrtt_pkg::ST_UNUSED)
                    begin
                        found = 1'b1;
                        model_state[slot] = rrtt_pkg::ST_READY;
                        model_stack[slot] = stk;
                        model_entry[slot] = ent;
                        r = slot_report(slot);
                    end
                end
            end
            rrtt_pkg::CMD_TICK:
            begin
                model_state[model_current] = rrtt_pkg::ST_PAUSED;
                for (slot = 1; slot <= rrtt_pkg::NUM_TASKS; slot++)
                begin
                    cand = (model_current + slot) % rrtt_pkg::NUM_TASKS;
                    if (!found && (model_state[cand] == rrtt_pkg::ST_READY ||
                                   model_state[cand] == rrtt_pkg::ST_PAUSED))
                    begin
                        found = 1'b1;
                        model_current = cand;
                    end
                end
                model_state[model_current] = rrtt_pkg::ST_RUNNING;
                r = slot_report(model_current);
            end
            rrtt_pkg::CMD_QUERY:
            begin
                if (int'(idx) < rrtt_pkg::NUM_TASKS)
                    r = slot_report(int'(idx));
                else
                    r.slot_id = idx;
            end
            default:
                r = '0;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, field, got,
                 want);
        error_count++;
    endtask

    always @(posedge clk)
    begin : result_check
        task_result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected item slot_id", {28'd0, slot_id}, '0);
            else
            begin
                want = expected_results.pop_front();
                if (slot_id !== want.slot_id)
                    report_mismatch("slot_id", {28'd0, slot_id}, {28'd0, want.slot_id});
                if (ok !== want.ok)
                    report_mismatch("ok", {31'd0, ok}, {31'd0, want.ok});
                if (slot_state !== want.slot_state)
                    report_mismatch("slot_state", {30'd0, slot_state},
                                    {30'd0, want.slot_state});
                if (slot_stack_size !== want.slot_stack_size)
                    report_mismatch("slot_stack_size", slot_stack_size,
                                    want.slot_stack_size);
                if (slot_entry !== want.slot_entry)
                    report_mismatch("slot_entry", slot_entry, want.slot_entry);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic idle_gap();
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start = 1'b0;
        end
    endtask

    task automatic send_item(input logic [1:0] cmd, input logic [31:0] stk,
                             input logic [31:0] ent, input logic [3:0] idx);
        idle_gap();
        @(negedge clk);
        start         = 1'b1;
        command       = cmd;
        stack_size    = stk;
        entry_address = ent;
        task_index    = idx;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_results.push_back(predict_table_result(cmd, stk, ent, idx));
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        start = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_tick_after_reset();
        // current slot is unused: it gets paused, then rescheduled
        send_item(rrtt_pkg::CMD_TICK, '0, '0, '0);
        send_item(rrtt_pkg::CMD_QUERY, '0, '0, 4'd0);
        send_item(rrtt_pkg::CMD_QUERY, '1, '1, rrtt_pkg::LAST_IDX);
        send_item(rrtt_pkg::CMD_TICK, '1, '1, 4'd15);
    endtask

    task automatic test_create_extremes();
        send_item(rrtt_pkg::CMD_CREATE, 32'h0000_0000, 32'h0000_0000, 4'd0);
        send_item(rrtt_pkg::CMD_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
        send_item(rrtt_pkg::CMD_CREATE, 32'h8000_0000, 32'h7FFF_FFFF, 4'd5);
        send_item(rrtt_pkg::CMD_CREATE, 32'h5555_5555, 32'hAAAA_AAAA, 4'd10);
        send_item(rrtt_pkg::CMD_QUERY, '0, '0, 4'd1);
        send_item(rrtt_pkg::CMD_QUERY, '0, '0, 4'd2);
        send_item(rrtt_pkg::CMD_QUERY, '0, '0, 4'd3);
        send_item(rrtt_pkg::CMD_QUERY, '0, '0, 4'd4);
    endtask

    task automatic test_tick_rotation();
        int n;
        for (n = 0; n < 6; n++)
            send_item(rrtt_pkg::CMD_TICK, $urandom, $urandom, 4'(n));
        for (n = 0; n < 5; n++)
            send_item(rrtt_pkg::CMD_QUERY, '0, '0, 4'(n));
    endtask

    task automatic test_unknown_command();
        send_item(CMD_UNKNOWN, '1, '1, 4'd15);
        send_item(CMD_UNKNOWN, '0, '0, 4'd0);
    endtask

    task automatic test_random_mix(input int count);
        int          n;
        int          pick;
        logic [1:0]  cmd;
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                cmd = rrtt_pkg::CMD_CREATE;
            else if (pick < 55)
                cmd = rrtt_pkg::CMD_TICK;
            else if (pick < 95)
                cmd = rrtt_pkg::CMD_QUERY;
            else
                cmd = CMD_UNKNOWN;
            send_item(cmd, pick_word(), pick_word(), 4'($urandom_range(15)));
        end
    endtask

    task automatic test_table_full();
        int n;
        for (n = 0; n < rrtt_pkg::NUM_TASKS + 2; n++)
            send_item(rrtt_pkg::CMD_CREATE, pick_word(), pick_word(),
                      4'($urandom_range(15)));
        for (n = 0; n < rrtt_pkg::NUM_TASKS; n++)
            send_item(rrtt_pkg::CMD_QUERY, '0, '0, 4'(n));
        for (n = 0; n < rrtt_pkg::NUM_TASKS + 2; n++)
            send_item(rrtt_pkg::CMD_TICK, '0, '0, '0);
    endtask

    initial
    begin
        int slot;
        rst_n         = 1'b0;
        start         = 1'b0;
        command       = rrtt_pkg::CMD_CREATE;
        stack_size    = '0;
        entry_address = '0;
        task_index    = '0;
        error_count   = 0;
        cycle_count   = 0;
        idle_pct      = 0;
        for (slot = 0; slot < rrtt_pkg::NUM_TASKS; slot++)
        begin
            model_state[slot] = rrtt_pkg::ST_UNUSED;
            model_stack[slot] = '0;
            model_entry[slot] = '0;
        end
        model_current = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_tick_after_reset();
        test_create_extremes();
        test_tick_rotation();
        test_unknown_command();
        wait_for_results();

        // receiver cannot stall, so its phases reduce to sender pacing
        idle_pct = 0;
        test_random_mix(80);
        wait_for_results();
        idle_pct = 75;
        test_random_mix(80);
        wait_for_results();
        idle_pct = 0;
        test_random_mix(80);
        idle_pct = 10;
        test_random_mix(80);
        wait_for_results();

        idle_pct = 10;
        test_table_full();
        wait_for_results();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
